// ===== design/feq_pkg.sv =====
// Shared types and constants for the float equal-mantissa-bits unit.
`default_nettype none
package feq_pkg;

  localparam int unsigned MantDig = 53;
  localparam logic [10:0] ExpMax = 11'h7FF;

  // Values handed from the align/add stage to the count stage.
  typedef struct packed {
    logic [56:0] sum;       // magnitude sum or difference, 3 extra low bits
    logic [10:0] el;        // effective exponent of the larger operand
    logic [10:0] ea;        // raw exponent field of x
    logic [10:0] eb;        // raw exponent field of y
    logic        is_eq;     // operands compare equal
    logic        special;   // an Inf or NaN operand, difference exponent all ones
  } s1_t;

  // Position of the leading set bit.
  function automatic logic [5:0] lead_pos(input logic [56:0] v);
    logic [5:0] q;
    q = '0;
    for (int i = 0; i < 57; i++) begin
      if (v[i]) q = 6'(i);
    end
    return q;
  endfunction

endpackage
`default_nettype wire

// ===== design/feq_if.sv =====
// Handshake channel interfaces for operand pairs and results.
`default_nettype none
interface feq_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] x_bits;
  logic [63:0] y_bits;
  modport source(output valid, output x_bits, output y_bits, input ready);
  modport sink(input valid, input x_bits, input y_bits, output ready);
endinterface

interface feq_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] equal_bits;
  modport source(output valid, output equal_bits, input ready);
  modport sink(input valid, input equal_bits, output ready);
endinterface
`default_nettype wire

// ===== design/feq_align.sv =====
// Operand compare, alignment and magnitude add/subtract.
`default_nettype none
module feq_align (
  input  logic [63:0]  x_bits_i,
  input  logic [63:0]  y_bits_i,
  output feq_pkg::s1_t s1_o
);
  import feq_pkg::*;

  logic [62:0]  xm, ym, lm, sm;
  logic         swap, sub, far, nan_x, nan_y;
  logic [10:0]  e_l, e_s, el_eff, es_eff, dexp;
  logic [52:0]  m_l, m_s;
  logic [5:0]   dc;
  logic [116:0] win;
  logic [55:0]  lx, sx;

  always_comb begin
    xm     = x_bits_i[62:0];
    ym     = y_bits_i[62:0];
    swap   = ym > xm;
    lm     = swap ? ym : xm;
    sm     = swap ? xm : ym;
    sub    = x_bits_i[63] == y_bits_i[63];
    e_l    = lm[62:52];
    e_s    = sm[62:52];
    m_l    = {|e_l, lm[51:0]};
    m_s    = {|e_s, sm[51:0]};
    el_eff = (e_l == '0) ? 11'd1 : e_l;
    es_eff = (e_s == '0) ? 11'd1 : e_s;
    dexp   = el_eff - es_eff;
    far    = dexp > 11'd63;
    dc     = far ? 6'd63 : dexp[5:0];
    win    = {m_s, 64'b0} >> dc;
    // guard, round, then sticky of everything shifted out
    sx     = {win[116:62], (|win[61:0]) | (far & |m_s)};
    lx     = {m_l, 3'b0};
    s1_o.sum = sub ? ({1'b0, lx} - {1'b0, sx}) : ({1'b0, lx} + {1'b0, sx});
    s1_o.el  = el_eff;
    s1_o.ea  = x_bits_i[62:52];
    s1_o.eb  = y_bits_i[62:52];
    nan_x  = (x_bits_i[62:52] == ExpMax) && (x_bits_i[51:0] != '0);
    nan_y  = (y_bits_i[62:52] == ExpMax) && (y_bits_i[51:0] != '0);
    s1_o.is_eq   = !nan_x && !nan_y &&
                   ((x_bits_i == y_bits_i) || (xm == '0 && ym == '0));
    s1_o.special = (x_bits_i[62:52] == ExpMax) || (y_bits_i[62:52] == ExpMax);
  end

endmodule
`default_nettype wire

// ===== design/feq_count.sv =====
// Normalize and round the difference exponent, then derive the agreeing bit count.
`default_nettype none
module feq_count (
  input  feq_pkg::s1_t s1_i,
  output logic [5:0]   equal_bits_o
);
  import feq_pkg::*;

  logic [5:0]         q;
  logic [56:0]        norm;
  logic               carry, subn;
  logic signed [14:0] e, ef, t, k, p, r;
  logic [10:0]        ed;

  always_comb begin
    q     = lead_pos(s1_i.sum);
    e     = $signed({4'b0, s1_i.el}) + $signed({9'b0, q}) - 15'sd55;
    norm  = s1_i.sum << (6'd56 - q);
    // round-to-nearest-even carry out of an all-ones significand
    carry = norm[3] & ((|norm[2:0]) | norm[4]) & (&norm[56:4]);
    ef    = e + $signed({14'b0, carry});
    subn  = !s1_i.special && (e <= 15'sd0);
    if (s1_i.special || ef >= 15'sd2047) ed = ExpMax;
    else if (subn) ed = '0;
    else ed = ef[10:0];
    t = $signed({4'b0, s1_i.ea}) + $signed({4'b0, s1_i.eb}) - 15'sd1
        - $signed({3'b0, ed, 1'b0});
    k = t >>> 1;
    // leading bit of the subnormal fraction
    p = $signed({9'b0, q}) + $signed({4'b0, s1_i.el}) - 15'sd4;
    if (subn) r = k + 15'sd52 - p;
    else if (k > 15'sd0) r = k + 15'sd1;
    else r = (k == 15'sd0 && s1_i.ea == s1_i.eb) ? 15'sd1 : 15'sd0;
    if (s1_i.is_eq) r = 15'(MantDig);
    if (r < 15'sd0) r = '0;
    if (r > 15'(MantDig)) r = 15'(MantDig);
    equal_bits_o = r[5:0];
  end

endmodule
`default_nettype wire

// ===== design/float_equal_mantissa_bits_unit.sv =====
// Top level: two-stage pipeline counting agreeing leading significand bits of two doubles.
// One operand pair per cycle is taken unless stalled; results are registered in stage
// one, then at the output. Stage one compares, aligns and adds or subtracts the
// significands; stage two finds the leading one, rounds the difference exponent and
// forms the count (0..53). A stall on the output holds the pipeline while filling bubbles.
`default_nettype none
module float_equal_mantissa_bits_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  feq_in_if.sink    in_i,
  feq_out_if.source out_o
);
  import feq_pkg::*;

  s1_t        s1_d, s1_q;
  logic       s1_v_q, out_v_q, en_out, en_s1;
  logic [5:0] bits_d, bits_q;

  feq_align u_align (.x_bits_i(in_i.x_bits), .y_bits_i(in_i.y_bits), .s1_o(s1_d));
  feq_count u_count (.s1_i(s1_q), .equal_bits_o(bits_d));

  assign en_out     = !out_v_q || out_o.ready;
  assign en_s1      = !s1_v_q || en_out;
  assign in_i.ready = en_s1;
  assign out_o.valid      = out_v_q;
  assign out_o.equal_bits = bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en_s1) s1_v_q <= in_i.valid;
      if (en_out) out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s1) s1_q <= s1_d;
    if (en_out) bits_q <= bits_d;
  end

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> bits_q <= 6'(MantDig)) else $error("count out of range");
  a_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && en_out && s1_q.is_eq) |=> bits_q == 6'(MantDig))
    else $error("equal operands not full count");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready) |=> out_v_q && $stable(bits_q))
    else $error("stalled result changed");
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_v_q) else $error("transfer lost");

endmodule
`default_nettype wire
